// ----- rtl/core/acs_pkg.sv -----
// Shared types, constants and control structs for the acquisition channel sequencer.
package acs_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DATA_W      = 32;
    localparam int PIN_LINES   = 6;
    localparam int CNT_W       = $clog2(DATA_W + 1);

    typedef enum logic [2:0] {
        K_ENABLE = 3'd0,
        K_TICK   = 3'd1,
        K_GET    = 3'd2,
        K_PUT    = 3'd3,
        K_FLUSH  = 3'd4,
        K_TRIG   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        CFG_CHANNEL_MODE  = 3'd0,
        CFG_MAX_POINTS    = 3'd1,
        CFG_MAX_REPEATS   = 3'd2,
        CFG_TRIGGER_MODE  = 3'd3,
        CFG_TRIGGER_LEVEL = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        RS_READY = 2'd0,
        RS_RUN   = 2'd1,
        RS_STOP  = 2'd2
    } t_run;

    localparam logic [3:0] TM_ANALOG_ABOVE = 4'd7;
    localparam logic [3:0] TM_ANALOG_BELOW = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_RD,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic latch;
        logic div_start;
        logic ram_rd;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/core/acs_ram.sv -----
// Generic single-port-write, registered-read RAM.
module acs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/core/acs_div.sv -----
// Bit-serial remainder unit: 32-bit count modulo the playback period.
module acs_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [acs_pkg::DATA_W-1:0] i_dividend,
    input  logic [acs_pkg::ADDR_W-1:0] i_divisor,
    output logic [acs_pkg::ADDR_W-1:0] o_rem,
    output logic                      o_done
);

    logic                       r_busy;
    logic [acs_pkg::CNT_W-1:0]  r_cnt;
    logic [acs_pkg::DATA_W-1:0] r_shift;
    logic [acs_pkg::ADDR_W:0]   r_rem;
    logic [acs_pkg::ADDR_W:0]   n_rem;
    logic [acs_pkg::ADDR_W:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[acs_pkg::ADDR_W-1:0], r_shift[acs_pkg::DATA_W-1]};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = w_trial - {1'b0, i_divisor};
        end else begin
            n_rem = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= acs_pkg::CNT_W'(acs_pkg::DATA_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == acs_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[acs_pkg::DATA_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_rem  = r_rem[acs_pkg::ADDR_W-1:0];
    assign o_done = !r_busy;

endmodule

// ----- rtl/core/acs_dp.sv -----
// Datapath: configuration, counters, sample store, remainder unit and result register.
module acs_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  acs_pkg::t_cmd        i_cmd,
    output acs_pkg::t_status     o_status,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [2:0]           i_kind,
    input  logic signed [31:0]   i_sample_value,
    input  logic [7:0]           i_store_index,
    input  logic [5:0]           i_pin_levels,
    input  logic signed [15:0]   i_analog_level,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic signed [31:0]   o_dac_value,
    output logic                 o_dac_drive,
    output logic signed [31:0]   o_read_value,
    output logic                 o_triggered,
    output logic                 o_run_done,
    output logic                 o_running
);

    localparam int AW = acs_pkg::ADDR_W;

    // configuration
    logic               r_channel_mode;
    logic [31:0]        r_max_points;
    logic [15:0]        r_max_repeats;
    logic [3:0]         r_trigger_mode;
    logic signed [15:0] r_trigger_level;

    // latched item
    logic [2:0]         r_kind;
    logic [31:0]        r_sample;
    logic [7:0]         r_idx;
    logic [5:0]         r_pins;
    logic signed [15:0] r_analog;

    // channel state
    logic [31:0]     r_write_count, n_write_count;
    logic [31:0]     r_read_count,  n_read_count;
    logic [31:0]     r_point_count, n_point_count;
    logic [15:0]     r_repeat_count, n_repeat_count;
    logic            r_settle, n_settle;
    acs_pkg::t_run   r_run, n_run;
    logic            r_end, n_end;

    logic [acs_pkg::STORE_DEPTH-1:0] r_valid;
    logic            r_rd_valid;

    logic            r_out_valid;
    logic [31:0]     n_dac_value, n_read_value;
    logic            n_dac_drive, n_triggered;

    logic [AW-1:0]   w_period;
    logic            w_period_zero;
    logic            w_tick_act;
    logic [AW-1:0]   w_rem;
    logic            w_div_done;
    logic [AW-1:0]   w_raddr;
    logic [31:0]     w_ram_q;
    logic [31:0]     w_rdata;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [31:0]     w_limit;
    logic [31:0]     w_point_inc;
    logic [15:0]     w_rep_inc;
    logic [2:0]      w_line;
    logic [5:0]      w_pin_sh;
    logic            w_pin_bit;
    logic            w_trig;

    assign w_period      = r_max_points[AW-1:0];
    assign w_period_zero = (w_period == '0);
    assign w_tick_act    = (r_kind == acs_pkg::K_TICK) && (r_run != acs_pkg::RS_STOP);

    assign o_status.need_div = r_channel_mode && !w_period_zero &&
                               (w_tick_act || r_kind == acs_pkg::K_GET);
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    acs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ((r_kind == acs_pkg::K_GET) ? r_read_count : r_write_count),
        .i_divisor  (w_period),
        .o_rem      (w_rem),
        .o_done     (w_div_done)
    );

    // enable always plays entry 0
    always_comb begin
        w_raddr = '0;
        if (r_kind == acs_pkg::K_ENABLE) begin
            w_raddr = '0;
        end else if (r_channel_mode) begin
            if (!w_period_zero) begin
                w_raddr = w_rem;
            end
        end else if (r_kind == acs_pkg::K_GET) begin
            w_raddr = r_read_count[AW-1:0];
        end
    end

    // store writes: capture tick or put
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_write_count[AW-1:0];
        if (i_cmd.exec) begin
            if (w_tick_act && !r_channel_mode) begin
                w_we = 1'b1;
            end else if (r_kind == acs_pkg::K_PUT &&
                         32'(r_idx) < acs_pkg::STORE_DEPTH) begin
                w_we    = 1'b1;
                w_waddr = AW'(r_idx);
            end
        end
    end

    acs_ram #(
        .WIDTH (32),
        .DEPTH (acs_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_sample),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // entries never written read as zero
    assign w_rdata = r_rd_valid ? w_ram_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ram_rd) begin
            r_rd_valid <= r_valid[w_raddr];
        end
    end

    // trigger evaluation
    always_comb begin
        w_line    = 3'(r_trigger_mode - 4'd1);
        w_pin_sh  = r_pins >> w_line;
        w_pin_bit = w_pin_sh[0];
        w_trig    = 1'b1;
        if (r_run == acs_pkg::RS_READY) begin
            if (r_trigger_mode >= 4'd1 && r_trigger_mode <= 4'(acs_pkg::PIN_LINES)) begin
                w_trig = (w_pin_bit  && r_trigger_level == 16'sd1) ||
                         (!w_pin_bit && r_trigger_level == 16'sd0);
            end else if (r_trigger_mode == acs_pkg::TM_ANALOG_ABOVE) begin
                w_trig = r_analog > r_trigger_level;
            end else if (r_trigger_mode == acs_pkg::TM_ANALOG_BELOW) begin
                w_trig = r_analog < r_trigger_level;
            end
        end
    end

    assign w_limit     = r_channel_mode ? 32'(w_period) : r_max_points;
    assign w_point_inc = r_point_count + 32'd1;
    assign w_rep_inc   = r_repeat_count + 16'd1;

    always_comb begin
        n_write_count  = r_write_count;
        n_read_count   = r_read_count;
        n_point_count  = r_point_count;
        n_repeat_count = r_repeat_count;
        n_settle       = r_settle;
        n_run          = r_run;
        n_end          = r_end;
        n_dac_value    = '0;
        n_dac_drive    = 1'b0;
        n_read_value   = '0;
        n_triggered    = 1'b0;
        case (r_kind)
            acs_pkg::K_ENABLE: begin
                n_end          = 1'b0;
                n_run          = acs_pkg::RS_RUN;
                n_point_count  = '0;
                n_repeat_count = '0;
                n_settle       = 1'b1;
                if (r_channel_mode) begin
                    n_dac_value = w_rdata;
                    n_dac_drive = 1'b1;
                end
            end
            acs_pkg::K_TICK: begin
                if (w_tick_act) begin
                    n_write_count = r_write_count + 32'd1;
                    if (r_channel_mode) begin
                        n_dac_value  = w_rdata;
                        n_dac_drive  = 1'b1;
                        n_read_count = r_write_count + 32'd1;
                    end
                    if (r_settle) begin
                        n_settle      = 1'b0;
                        n_write_count = '0;
                    end else begin
                        n_point_count = w_point_inc;
                        if (w_point_inc == w_limit) begin
                            if (r_max_repeats == '0) begin
                                n_point_count = '0;
                            end else begin
                                n_repeat_count = w_rep_inc;
                                if (r_max_repeats > w_rep_inc) begin
                                    n_point_count = '0;
                                end else begin
                                    n_run = acs_pkg::RS_STOP;
                                    n_end = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            acs_pkg::K_GET: begin
                n_read_value = w_rdata;
                if (r_read_count < r_write_count) begin
                    n_read_count = r_read_count + 32'd1;
                end
            end
            acs_pkg::K_FLUSH: begin
                n_write_count  = '0;
                n_read_count   = '0;
                n_point_count  = '0;
                n_repeat_count = '0;
            end
            acs_pkg::K_TRIG: begin
                n_triggered = w_trig;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_mode  <= 1'b0;
            r_max_points    <= '0;
            r_max_repeats   <= '0;
            r_trigger_mode  <= '0;
            r_trigger_level <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                acs_pkg::CFG_CHANNEL_MODE:  r_channel_mode  <= i_cfg_data[0];
                acs_pkg::CFG_MAX_POINTS:    r_max_points    <= i_cfg_data;
                acs_pkg::CFG_MAX_REPEATS:   r_max_repeats   <= i_cfg_data[15:0];
                acs_pkg::CFG_TRIGGER_MODE:  r_trigger_mode  <= i_cfg_data[3:0];
                acs_pkg::CFG_TRIGGER_LEVEL: r_trigger_level <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind   <= i_kind;
            r_sample <= i_sample_value;
            r_idx    <= i_store_index;
            r_pins   <= i_pin_levels;
            r_analog <= i_analog_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_count  <= '0;
            r_read_count   <= '0;
            r_point_count  <= '0;
            r_repeat_count <= '0;
            r_settle       <= 1'b0;
            r_run          <= acs_pkg::RS_READY;
            r_end          <= 1'b0;
        end else if (i_cmd.exec) begin
            r_write_count  <= n_write_count;
            r_read_count   <= n_read_count;
            r_point_count  <= n_point_count;
            r_repeat_count <= n_repeat_count;
            r_settle       <= n_settle;
            r_run          <= n_run;
            r_end          <= n_end;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_dac_value   <= n_dac_value;
            o_dac_drive   <= n_dac_drive;
            o_read_value  <= n_read_value;
            o_triggered   <= n_triggered;
            o_run_done    <= n_end;
            o_running     <= (n_run == acs_pkg::RS_RUN);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/acs_ctrl.sv -----
// Controller: sequences latch, remainder, store read and execute for each command.
module acs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  acs_pkg::t_status i_status,
    output acs_pkg::t_cmd    o_cmd
);

    acs_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            acs_pkg::S_IDLE: if (i_in_valid) n_state = acs_pkg::S_PREP;
            acs_pkg::S_PREP: n_state = i_status.need_div ? acs_pkg::S_DIV : acs_pkg::S_RD;
            acs_pkg::S_DIV:  if (i_status.div_done) n_state = acs_pkg::S_RD;
            acs_pkg::S_RD:   n_state = acs_pkg::S_EXEC;
            acs_pkg::S_EXEC: if (i_status.out_free) n_state = acs_pkg::S_IDLE;
            default:         n_state = acs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        unique case (r_state)
            acs_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            acs_pkg::S_PREP: o_cmd.div_start = i_status.need_div;
            acs_pkg::S_RD:   o_cmd.ram_rd    = 1'b1;
            acs_pkg::S_EXEC: o_cmd.exec      = i_status.out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/acquisition_channel_sequencer.sv -----
// Top level of the acquisition channel sequencer.
// Usage:
//  - Command channel (i_in_valid/o_in_ready) carries one command per transfer:
//    enable, tick, get, put, flush or trigger check, with its operand fields.
//  - Result channel (o_out_valid/i_out_ready) returns exactly one result per command.
//  - Configuration channel (i_cfg_valid/o_cfg_ready) is always ready; write it
//    only while the channel is idle.
//  - Steps: a taken command is latched, then prepared, then the store is read and
//    the command executes into the result register. Playback ticks (when not
//    stopped) and playback gets with a non-zero period also pass the
//    bit-serial remainder unit (one bit of the 32-bit count per cycle), which
//    forms the playback address, between preparation and the store read.
//  - The block holds one command at a time.
//  - The result sits in an output register; a stalled receiver holds it there,
//    and the next command may be taken meanwhile but waits to execute.
//  - Reset (synchronous, active low) clears counters, run state, configuration
//    and the per-entry valid bits, so every store entry reads as zero.
module acquisition_channel_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_sample_value,
    input  logic [7:0]         i_store_index,
    input  logic [5:0]         i_pin_levels,
    input  logic signed [15:0] i_analog_level,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_dac_value,
    output logic               o_dac_drive,
    output logic signed [31:0] o_read_value,
    output logic               o_triggered,
    output logic               o_run_done,
    output logic               o_running
);

    acs_pkg::t_cmd    w_cmd;
    acs_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    acs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    acs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_sample_value (i_sample_value),
        .i_store_index  (i_store_index),
        .i_pin_levels   (i_pin_levels),
        .i_analog_level (i_analog_level),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_dac_value    (o_dac_value),
        .o_dac_drive    (o_dac_drive),
        .o_read_value   (o_read_value),
        .o_triggered    (o_triggered),
        .o_run_done     (o_run_done),
        .o_running      (o_running)
    );

endmodule

// ----- rtl/core/acs_checker.sv -----
// Port-level checks for the acquisition channel sequencer, bound to the top level.
module acs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_dac_value,
    input logic        o_dac_drive,
    input logic [31:0] o_read_value,
    input logic        o_triggered
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_dac_value) && $stable(o_read_value))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command taken while one is in work");

    a_drive_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dac_drive |-> o_read_value == 32'd0 && !o_triggered)
        else $error("DAC result mixed with get or trigger result");

    a_no_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_dac_drive |-> o_dac_value == 32'd0)
        else $error("DAC value without drive");

endmodule

bind acquisition_channel_sequencer acs_checker u_acs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_dac_value  (o_dac_value),
    .o_dac_drive  (o_dac_drive),
    .o_read_value (o_read_value),
    .o_triggered  (o_triggered)
);

// ----- test/acs_checker.sv -----
// Checker for the acquisition channel sequencer: watches transfers, predicts results, compares.
module acs_scoreboard
    import acs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_sample_value,
    input  logic [7:0]         i_store_index,
    input  logic [5:0]         i_pin_levels,
    input  logic signed [15:0] i_analog_level,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_dac_value,
    input  logic               i_dac_drive,
    input  logic signed [31:0] i_read_value,
    input  logic               i_triggered,
    input  logic               i_run_done,
    input  logic               i_running,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [31:0] dac_value;
        logic        dac_drive;
        logic [31:0] read_value;
        logic        triggered;
        logic        run_done;
        logic        running;
    } t_result;

    logic [31:0] store [STORE_DEPTH];
    logic [31:0] wr_cnt, rd_cnt, pt_cnt;
    logic [15:0] rep_cnt;
    logic        settling, ended;
    t_run        rstate;

    logic        m_mode;
    logic [31:0] m_points;
    logic [15:0] m_repeats;
    logic [3:0]  m_tmode;
    logic signed [15:0] m_tlevel;

    t_result expected_q[$];

    assign o_pending = expected_q.size();

    function automatic logic [31:0] period();
        return m_mode ? (m_points % STORE_DEPTH) : m_points;
    endfunction

    function automatic logic [31:0] play_index(logic [31:0] c);
        logic [31:0] p;
        p = period();
        return (p == 0) ? 32'd0 : c % p;
    endfunction

    task automatic predict(input logic [2:0] k, input logic [31:0] smp, input logic [7:0] idx,
                           input logic [5:0] pins, input logic signed [15:0] ana);
        t_result r;
        logic [31:0] lim;
        logic [31:0] a;
        r = '0;
        case (k)
            K_ENABLE: begin
                ended = 1'b0;
                rstate = RS_RUN;
                pt_cnt = '0;
                rep_cnt = '0;
                settling = 1'b1;
                if (m_mode) begin
                    r.dac_value = store[0];
                    r.dac_drive = 1'b1;
                end
            end
            K_TICK: begin
                if (rstate != RS_STOP) begin
                    lim = period();
                    if (m_mode) begin
                        r.dac_value = store[play_index(wr_cnt)];
                        r.dac_drive = 1'b1;
                        wr_cnt = wr_cnt + 32'd1;
                        rd_cnt = wr_cnt;
                    end else begin
                        store[wr_cnt % STORE_DEPTH] = smp;
                        wr_cnt = wr_cnt + 32'd1;
                    end
                    if (settling) begin
                        settling = 1'b0;
                        wr_cnt = '0;
                    end else begin
                        pt_cnt = pt_cnt + 32'd1;
                        if (pt_cnt == lim) begin
                            if (m_repeats == 0) begin
                                pt_cnt = '0;
                            end else begin
                                rep_cnt = rep_cnt + 16'd1;
                                if (m_repeats > rep_cnt) begin
                                    pt_cnt = '0;
                                end else begin
                                    rstate = RS_STOP;
                                    ended = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            K_GET: begin
                a = m_mode ? play_index(rd_cnt) : rd_cnt % STORE_DEPTH;
                r.read_value = store[a];
                if (rd_cnt < wr_cnt) rd_cnt = rd_cnt + 32'd1;
            end
            K_PUT: begin
                if (idx < STORE_DEPTH) store[idx] = smp;
            end
            K_FLUSH: begin
                wr_cnt = '0;
                rd_cnt = '0;
                pt_cnt = '0;
                rep_cnt = '0;
            end
            K_TRIG: begin
                if (rstate != RS_READY) r.triggered = 1'b1;
                else if (m_tmode >= 1 && m_tmode <= PIN_LINES)
                    r.triggered = ($signed({1'b0, pins[m_tmode - 1]}) == m_tlevel);
                else if (m_tmode == TM_ANALOG_ABOVE) r.triggered = ana > m_tlevel;
                else if (m_tmode == TM_ANALOG_BELOW) r.triggered = ana < m_tlevel;
                else r.triggered = 1'b1;
            end
            default: ;
        endcase
        r.run_done = ended;
        r.running = (rstate == RS_RUN);
        expected_q.push_back(r);
    endtask

    task automatic compare(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            foreach (store[i]) store[i] = '0;
            wr_cnt = 0; rd_cnt = 0; pt_cnt = 0; rep_cnt = '0;
            settling = 0; ended = 0; rstate = RS_READY;
            m_mode = 0; m_points = 0; m_repeats = '0; m_tmode = '0; m_tlevel = '0;
            expected_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_CHANNEL_MODE:  m_mode = i_cfg_data[0];
                    CFG_MAX_POINTS:    m_points = i_cfg_data;
                    CFG_MAX_REPEATS:   m_repeats = i_cfg_data[15:0];
                    CFG_TRIGGER_MODE:  m_tmode = i_cfg_data[3:0];
                    CFG_TRIGGER_LEVEL: m_tlevel = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict(i_kind, i_sample_value, i_store_index, i_pin_levels, i_analog_level);
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_errors++;
                end else begin
                    e = expected_q.pop_front();
                    compare("dac_value", e.dac_value, i_dac_value);
                    compare("dac_drive", 32'(e.dac_drive), 32'(i_dac_drive));
                    compare("read_value", e.read_value, i_read_value);
                    compare("triggered", 32'(e.triggered), 32'(i_triggered));
                    compare("run_done", 32'(e.run_done), 32'(i_run_done));
                    compare("running", 32'(e.running), 32'(i_running));
                end
            end
        end
    end

endmodule

// ----- test/tb.sv -----
// Testbench top: stimulus, configuration phases and final verdict for the channel sequencer.
module tb;
    import acs_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = 0;
    logic [31:0]        i_cfg_data = 0;
    logic               i_in_valid = 0;
    logic               o_in_ready;
    logic [2:0]         i_kind = 0;
    logic signed [31:0] i_sample_value = 0;
    logic [7:0]         i_store_index = 0;
    logic [5:0]         i_pin_levels = 0;
    logic signed [15:0] i_analog_level = 0;
    logic               o_out_valid;
    logic               i_out_ready = 0;
    logic signed [31:0] o_dac_value;
    logic               o_dac_drive;
    logic signed [31:0] o_read_value;
    logic               o_triggered;
    logic               o_run_done;
    logic               o_running;
    int                 errors, pending;
    bit                 calm = 0;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    acquisition_channel_sequencer dut (.*);

    acs_scoreboard chk (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_kind, .i_sample_value, .i_store_index,
        .i_pin_levels, .i_analog_level, .i_out_valid(o_out_valid), .i_out_ready,
        .i_dac_value(o_dac_value), .i_dac_drive(o_dac_drive), .i_read_value(o_read_value),
        .i_triggered(o_triggered), .i_run_done(o_run_done), .i_running(o_running),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        int stall;
        if (stall > 0) begin
            stall--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 7) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // valid is left high after the transfer; the next send_cmd call drops it
    task automatic write_reg(input t_cfg_reg r, input logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic send_cmd(input t_kind k, input logic [31:0] smp, input logic [7:0] idx,
                            input logic [5:0] pins, input logic [15:0] ana);
        int gap;
        i_cfg_valid <= 1'b0;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= k;
        i_sample_value <= smp;
        i_store_index  <= idx;
        i_pin_levels   <= pins;
        i_analog_level <= ana;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic settle_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic random_cmd(input int bias);
        t_kind k;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) k = K_ENABLE;
        else if (r < 5 + bias) k = K_TICK;
        else if (r < 70) k = K_GET;
        else if (r < 85) k = K_PUT;
        else if (r < 90) k = K_FLUSH;
        else k = K_TRIG;
        send_cmd(k, $urandom, 8'($urandom), 6'($urandom), 16'($urandom));
    endtask

    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: capture with short run, extremes of fields
        write_reg(CFG_MAX_POINTS, 3);
        write_reg(CFG_MAX_REPEATS, 2);
        write_reg(CFG_TRIGGER_MODE, 3);
        write_reg(CFG_TRIGGER_LEVEL, 1);
        send_cmd(K_TRIG, 0, 0, 6'h3f, 16'h7fff);
        send_cmd(K_TRIG, 0, 0, 6'h00, 16'h8000);
        send_cmd(K_PUT, 32'h7fffffff, 8'd255, 0, 0);
        send_cmd(K_PUT, 32'h80000000, 8'd0, 0, 0);
        send_cmd(K_GET, 0, 0, 0, 0);
        send_cmd(K_ENABLE, 0, 0, 0, 0);
        send_cmd(K_TRIG, 0, 0, 0, 0);
        repeat (8) send_cmd(K_TICK, $urandom, 0, 0, 0);
        send_cmd(K_TICK, 32'hffffffff, 0, 0, 0);  // ignored while stopped
        send_cmd(K_TRIG, 0, 0, 0, 0);
        repeat (3) send_cmd(K_GET, 0, 0, 0, 0);
        send_cmd(K_FLUSH, 0, 0, 0, 0);
        send_cmd(t_kind'(3'd6), 0, 0, 0, 0);
        send_cmd(t_kind'(3'd7), 0, 0, 0, 0);
        settle_idle();

        // directed: playback, then phases over random settings
        write_reg(CFG_CHANNEL_MODE, 1);
        write_reg(CFG_MAX_POINTS, 32'hffffffff);
        write_reg(CFG_MAX_REPEATS, 16'hffff);
        write_reg(CFG_TRIGGER_MODE, 15);
        write_reg(CFG_TRIGGER_LEVEL, 32'h8000);
        send_cmd(K_ENABLE, 0, 0, 0, 0);
        repeat (4) send_cmd(K_TICK, 0, 0, 0, 0);
        send_cmd(K_GET, 0, 0, 0, 0);
        settle_idle();

        for (int ph = 0; ph < 18; ph++) begin
            int n;
            if (ph == 17) calm = 1;
            write_reg(CFG_CHANNEL_MODE, $urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_MAX_POINTS, 0);
                1: write_reg(CFG_MAX_POINTS, 256 * $urandom_range(0, 3));
                2: write_reg(CFG_MAX_POINTS, $urandom);
                default: write_reg(CFG_MAX_POINTS, $urandom_range(1, 12));
            endcase
            write_reg(CFG_MAX_REPEATS, ($urandom_range(0, 3) == 0) ? 16'hffff
                                                                   : $urandom_range(0, 4));
            write_reg(CFG_TRIGGER_MODE, $urandom_range(0, 15));
            write_reg(CFG_TRIGGER_LEVEL, $urandom_range(0, 2) == 0 ? $urandom_range(0, 1)
                                                                   : $urandom);
            if (ph == 0) begin
                // trigger checks after the channel has left the ready state
                repeat (3) send_cmd(K_TRIG, 0, 0, 6'($urandom), 16'($urandom));
            end
            n = 75;
            for (int i = 0; i < n; i++) begin
                if (i == 40 && ph == 5) begin
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (pending != 0);
                end
                random_cmd(40);
            end
            settle_idle();
        end

        settle_idle();
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
